// File: hdl/single_wire_sensor_frame_receiver_core_assert.svh
// Assertion macros used by the frame receiver core.
// Needs no other file; ASSERT_OFF compiles them to nothing.
`ifndef SINGLE_WIRE_SENSOR_FRAME_RECEIVER_CORE_ASSERT_SVH
`define SINGLE_WIRE_SENSOR_FRAME_RECEIVER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// expr must hold at every clock edge outside reset
`define SWSFR_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("swsfr invariant violated");
// cons must hold in the cycle after ante
`define SWSFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("swsfr sequence violated");
`else
`define SWSFR_ASSERT_ALWAYS(label, clk, rst, expr)
`define SWSFR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: hdl/swsfr_pkg.sv
// Shared types and constants of the single-wire sensor frame receiver.
// No dependencies; used by swsfr_step and the core.
package swsfr_pkg;

   localparam int TICK_WIDTH      = 16;
   localparam int FRAME_BYTES     = 5;
   localparam int CSR_INDEX_WIDTH = 3;

   // item kinds
   localparam logic [1:0] REQ_START  = 2'd0;
   localparam logic [1:0] REQ_PULSE  = 2'd1;
   localparam logic [1:0] REQ_FINISH = 2'd2;

   // phase codes
   localparam logic [2:0] PH_IDLE       = 3'd0;
   localparam logic [2:0] PH_RESPONSE   = 3'd1;
   localparam logic [2:0] PH_FIRST_BYTE = 3'd2;
   localparam logic [2:0] PH_LAST_BYTE  = 3'd6;

   // status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_HOST_INIT = 3'd1;
   localparam logic [2:0] ST_RESPONSE  = 3'd2;
   localparam logic [2:0] ST_DATA      = 3'd3;
   localparam logic [2:0] ST_CHECKSUM  = 3'd4;

   // low bytes substituted into both words on a failed finish
   localparam logic [7:0] LO_BAD_SUM    = 8'd4;
   localparam logic [7:0] LO_INCOMPLETE = 8'd2;

   localparam logic [2:0] BIT_MSB = 3'd7;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HOST_RELEASE_MIN = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HOST_RELEASE_MAX = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RESPONSE_MIN     = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RESPONSE_MAX     = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ZERO_HIGH_MAX    = 3'd4;

   // register reset values
   localparam logic [TICK_WIDTH-1:0] HOST_RELEASE_MIN_RST = 16'd10;
   localparam logic [TICK_WIDTH-1:0] HOST_RELEASE_MAX_RST = 16'd50;
   localparam logic [TICK_WIDTH-1:0] RESPONSE_MIN_RST     = 16'd60;
   localparam logic [TICK_WIDTH-1:0] RESPONSE_MAX_RST     = 16'd100;
   localparam logic [TICK_WIDTH-1:0] ZERO_HIGH_MAX_RST    = 16'd40;

   typedef struct packed {
      logic [TICK_WIDTH-1:0] host_release_min;
      logic [TICK_WIDTH-1:0] host_release_max;
      logic [TICK_WIDTH-1:0] response_min;
      logic [TICK_WIDTH-1:0] response_max;
      logic [TICK_WIDTH-1:0] zero_high_max;
   } cfg_type;

   typedef struct packed {
      logic [2:0]                  phase;
      logic [2:0]                  bit_index;
      logic [FRAME_BYTES-1:0][7:0] frame_bytes;
      logic [2:0]                  status;
   } frame_state_type;

endpackage

// File: hdl/swsfr_step.sv
// Next-state logic of the frame receiver for one item.
// Depends on swsfr_pkg.
module swsfr_step (
   input  swsfr_pkg::cfg_type         cfg,
   input  swsfr_pkg::frame_state_type cur,
   input  logic [1:0]                 req_type,
   input  logic [swsfr_pkg::TICK_WIDTH-1:0] pulse_ticks,
   output swsfr_pkg::frame_state_type nxt
);

   logic [2:0] byte_sel;
   logic [2:0] bit_pos;
   logic [2:0] bit_next;
   logic [7:0] sum;
   logic       bit_one;
   logic       host_ok;
   logic       resp_ok;

   assign byte_sel = cur.phase - swsfr_pkg::PH_FIRST_BYTE;
   assign bit_pos  = swsfr_pkg::BIT_MSB - cur.bit_index;
   assign bit_next = cur.bit_index + 3'd1;
   assign sum      = cur.frame_bytes[0] + cur.frame_bytes[1]
                   + cur.frame_bytes[2] + cur.frame_bytes[3];
   assign bit_one  = pulse_ticks > cfg.zero_high_max;
   assign host_ok  = (pulse_ticks > cfg.host_release_min) &&
                     (pulse_ticks < cfg.host_release_max);
   assign resp_ok  = (pulse_ticks > cfg.response_min) &&
                     (pulse_ticks < cfg.response_max);

   always_comb begin
      nxt = cur;
      case (req_type)
         swsfr_pkg::REQ_START: begin
            nxt        = '0;
            nxt.phase  = swsfr_pkg::PH_IDLE;
            nxt.status = swsfr_pkg::ST_HOST_INIT;
         end
         swsfr_pkg::REQ_PULSE: begin
            if (cur.phase == swsfr_pkg::PH_IDLE) begin
               if (host_ok) nxt.phase = swsfr_pkg::PH_RESPONSE;
               nxt.status = swsfr_pkg::ST_RESPONSE;
            end else if (cur.phase == swsfr_pkg::PH_RESPONSE) begin
               if (resp_ok) begin
                  nxt.phase     = swsfr_pkg::PH_FIRST_BYTE;
                  nxt.bit_index = '0;
               end
               nxt.status = swsfr_pkg::ST_DATA;
            end else if (cur.phase inside
                         {[swsfr_pkg::PH_FIRST_BYTE:swsfr_pkg::PH_LAST_BYTE]}) begin
               for (int i = 0; i < swsfr_pkg::FRAME_BYTES; i++) begin
                  if (bit_one && byte_sel == 3'(i))
                     nxt.frame_bytes[i][bit_pos] = 1'b1;
               end
               nxt.bit_index = bit_next;
               if (bit_next == 3'd0) begin
                  if (cur.phase == swsfr_pkg::PH_LAST_BYTE) begin
                     nxt.phase  = swsfr_pkg::PH_IDLE;
                     nxt.status = swsfr_pkg::ST_CHECKSUM;
                  end else begin
                     nxt.phase  = cur.phase + 3'd1;
                     nxt.status = swsfr_pkg::ST_DATA;
                  end
               end
            end
         end
         swsfr_pkg::REQ_FINISH: begin
            if (cur.status == swsfr_pkg::ST_CHECKSUM) begin
               if (sum == cur.frame_bytes[4]) begin
                  nxt.status = swsfr_pkg::ST_OK;
               end else begin
                  nxt.frame_bytes[0] = 8'd0;
                  nxt.frame_bytes[1] = swsfr_pkg::LO_BAD_SUM;
                  nxt.frame_bytes[2] = 8'd0;
                  nxt.frame_bytes[3] = swsfr_pkg::LO_BAD_SUM;
               end
            end else begin
               nxt.frame_bytes[0] = 8'd0;
               nxt.frame_bytes[1] = swsfr_pkg::LO_INCOMPLETE;
               nxt.frame_bytes[2] = 8'd0;
               nxt.frame_bytes[3] = swsfr_pkg::LO_INCOMPLETE;
            end
         end
         default: ;  // unused code leaves the state alone
      endcase
   end

endmodule

// File: hdl/single_wire_sensor_frame_receiver_core.sv
// Accepted items wait in the input register until the step logic updates the frame state.
// Throughput: one item per cycle; only a stalled result holds back the input register.
// The frame state register doubles as the result register, so it moves only when the
// result side can take a new item.
// Reset (synchronous, active high) clears both valids, sets phase idle, status host
// init, clears the frame bytes and loads the register defaults.
`include "single_wire_sensor_frame_receiver_core_assert.svh"

module single_wire_sensor_frame_receiver_core (
   input  logic                                   clock,
   input  logic                                   reset,
   // item input
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [1:0]                             req_type,
   input  logic [swsfr_pkg::TICK_WIDTH-1:0]       req_pulse_ticks,
   // result output
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [2:0]                             rsp_status,
   output logic [15:0]                            rsp_humidity_word,
   output logic [15:0]                            rsp_temperature_word,
   output logic [7:0]                             rsp_checksum_byte,
   output logic [2:0]                             rsp_phase,
   // register writes
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [swsfr_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [swsfr_pkg::TICK_WIDTH-1:0]       csr_wdata
);

   // input register (item waiting for the step logic)
   logic                               in_valid_ff, in_valid_in;
   logic [1:0]                         in_type_ff;
   logic [swsfr_pkg::TICK_WIDTH-1:0]   in_ticks_ff;

   // frame state, also the result payload
   swsfr_pkg::frame_state_type         state_ff, state_in, state_step;
   logic                               rsp_valid_ff, rsp_valid_in;

   swsfr_pkg::cfg_type                 cfg_ff, cfg_in;

   logic advance;   // result slot free or being taken this edge
   logic req_take;

   // Result slot can be refilled when empty or when its item leaves now.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   // writes must be issued only while idle (the block does not enforce this); the port is always open
   assign csr_ready = 1'b1;

   swsfr_step u_step (
      .cfg         (cfg_ff),
      .cur         (state_ff),
      .req_type    (in_type_ff),
      .pulse_ticks (in_ticks_ff),
      .nxt         (state_step)
   );

   always_comb begin
      in_valid_in  = (in_valid_ff && !advance) || req_take;
      rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;
      state_in     = (advance && in_valid_ff) ? state_step : state_ff;
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            swsfr_pkg::CSR_HOST_RELEASE_MIN: cfg_in.host_release_min = csr_wdata;
            swsfr_pkg::CSR_HOST_RELEASE_MAX: cfg_in.host_release_max = csr_wdata;
            swsfr_pkg::CSR_RESPONSE_MIN:     cfg_in.response_min     = csr_wdata;
            swsfr_pkg::CSR_RESPONSE_MAX:     cfg_in.response_max     = csr_wdata;
            swsfr_pkg::CSR_ZERO_HIGH_MAX:    cfg_in.zero_high_max    = csr_wdata;
            default: ;  // writes past the list are dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '{phase:       swsfr_pkg::PH_IDLE,
                           bit_index:   3'd0,
                           frame_bytes: '0,
                           status:      swsfr_pkg::ST_HOST_INIT};
         cfg_ff       <= '{host_release_min: swsfr_pkg::HOST_RELEASE_MIN_RST,
                           host_release_max: swsfr_pkg::HOST_RELEASE_MAX_RST,
                           response_min:     swsfr_pkg::RESPONSE_MIN_RST,
                           response_max:     swsfr_pkg::RESPONSE_MAX_RST,
                           zero_high_max:    swsfr_pkg::ZERO_HIGH_MAX_RST};
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
         cfg_ff       <= cfg_in;
      end
   end

   // payload of the input register needs no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_type_ff  <= req_type;
         in_ticks_ff <= req_pulse_ticks;
      end
   end

   // result fields straight from the frame state
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = state_ff.status;
   assign rsp_humidity_word    = {state_ff.frame_bytes[0], state_ff.frame_bytes[1]};
   assign rsp_temperature_word = {state_ff.frame_bytes[2], state_ff.frame_bytes[3]};
   assign rsp_checksum_byte    = state_ff.frame_bytes[4];
   assign rsp_phase            = state_ff.phase;

   // ---- checks ----
   // outside a byte phase the bit counter is always back at zero
   `SWSFR_ASSERT_ALWAYS(a_bit_index_idle, clock, reset,
      (state_ff.phase != swsfr_pkg::PH_IDLE && state_ff.phase != swsfr_pkg::PH_RESPONSE)
      || state_ff.bit_index == 3'd0)
   // checksum pending or ok only once the frame is back in idle
   `SWSFR_ASSERT_ALWAYS(a_status_phase, clock, reset,
      (state_ff.status != swsfr_pkg::ST_OK && state_ff.status != swsfr_pkg::ST_CHECKSUM)
      || state_ff.phase == swsfr_pkg::PH_IDLE)
   // a waiting item that moves on always produces a result
   `SWSFR_ASSERT_NEXT(a_item_to_result, clock, reset, in_valid_ff && advance, rsp_valid_ff)
   // the frame state never moves while a result is held
   `SWSFR_ASSERT_NEXT(a_state_held, clock, reset, rsp_valid_ff && rsp_stall,
      $stable(state_ff))

endmodule
